// ----- src/stxp_pkg.sv -----
// ----------------------------------------------------------------------------
// stxp_pkg
// shared types and constants of the stx/etx command frame parser
// ----------------------------------------------------------------------------
`default_nettype none

package stxp_pkg;

    localparam int BUFFER_DEPTH_DEFAULT = 128;

    localparam logic [7:0] START_BYTE     = 8'h02;
    localparam logic [7:0] END_BYTE       = 8'h03;
    localparam logic [7:0] CMD_SET_TARGET = 8'h54;
    localparam logic [7:0] SET_TARGET_LEN = 8'd9;
    localparam int         KEPT_BYTES     = 7;

    localparam logic [7:0] DEVICE_ID_FIRST_RESET  = 8'd70;
    localparam logic [7:0] DEVICE_ID_SECOND_RESET = 8'd49;

    localparam logic CFG_DEVICE_ID_FIRST  = 1'b0;
    localparam logic CFG_DEVICE_ID_SECOND = 1'b1;

    typedef enum logic [2:0] {
        ST_ID_MATCHED   = 3'd0,
        ST_VOLUME_SET   = 3'd1,
        ST_LENGTH_ERROR = 3'd2,
        ST_WRONG_ID     = 3'd3,
        ST_OVERFLOW     = 3'd4
    } status_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] target_volume;
        logic [7:0]  frame_length;
        logic [15:0] received_id;
    } result_t;

    typedef struct packed {
        logic [7:0] device_id_first;
        logic [7:0] device_id_second;
    } cfg_t;

endpackage

`default_nettype wire

// ----- src/stxp_if.sv -----
// ----------------------------------------------------------------------------
// stxp channel interfaces
// byte input channel and result output channel, valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface stxp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface stxp_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] target_volume;
    logic [7:0]  frame_length;
    logic [15:0] received_id;

    modport source (output valid, output status, output target_volume,
                    output frame_length, output received_id, input ready);
    modport sink   (input valid, input status, input target_volume,
                    input frame_length, input received_id, output ready);
endinterface

`default_nettype wire

// ----- src/stxp_frame_decode.sv -----
// ----------------------------------------------------------------------------
// stxp_frame_decode
// byte position, kept header/payload bytes and per-byte result decode
// ----------------------------------------------------------------------------
`default_nettype none

module stxp_frame_decode
    import stxp_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEFAULT
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    accept,
    input  wire logic [7:0] rx_byte,
    input  wire cfg_t    cfg,
    output logic         has_result,
    output result_t      result
);

    localparam int POS_W = $clog2(BUFFER_DEPTH);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [7:0]       hdr_reg [1:KEPT_BYTES];

    logic             is_start;
    logic             is_end;
    logic             id_ok;
    logic [POS_W:0]   pos_inc;
    logic [7:0]       frame_len;
    logic             wr_en;
    logic [7:0]       wr_data;

    assign is_start  = (rx_byte == START_BYTE);
    assign is_end    = (rx_byte == END_BYTE);
    assign id_ok     = (hdr_reg[1] == cfg.device_id_first)
                    && (hdr_reg[2] == cfg.device_id_second);
    assign pos_inc   = {1'b0, pos_reg} + {{POS_W{1'b0}}, 1'b1};
    assign frame_len = 8'(pos_reg) + 8'd1;

    always_comb
    begin
        has_result = 1'b0;
        result     = '0;
        pos_next   = pos_reg;
        wr_en      = 1'b0;
        wr_data    = rx_byte;
        if (is_start)
        begin
            pos_next = POS_W'(1);
        end
        else if (is_end)
        begin
            pos_next   = '0;
            has_result = 1'b1;
            if (!id_ok)
            begin
                result.status      = ST_WRONG_ID;
                result.received_id = {hdr_reg[1], hdr_reg[2]};
            end
            else if (hdr_reg[3] != CMD_SET_TARGET)
            begin
                result.status = ST_ID_MATCHED;
            end
            else if (frame_len == SET_TARGET_LEN)
            begin
                result.status        = ST_VOLUME_SET;
                result.target_volume = {hdr_reg[7], hdr_reg[6], hdr_reg[5], hdr_reg[4]};
            end
            else
            begin
                // bad length leaves the end byte in the buffer
                wr_en               = 1'b1;
                wr_data             = END_BYTE;
                result.status       = ST_LENGTH_ERROR;
                result.frame_length = frame_len;
            end
        end
        else
        begin
            wr_en = 1'b1;
            if (pos_inc >= (POS_W+1)'(BUFFER_DEPTH))
            begin
                pos_next      = '0;
                has_result    = 1'b1;
                result.status = ST_OVERFLOW;
            end
            else
            begin
                pos_next = pos_inc[POS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            for (int i = 1; i <= KEPT_BYTES; i++)
            begin
                hdr_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
            for (int i = 1; i <= KEPT_BYTES; i++)
            begin
                if (wr_en && (pos_reg == POS_W'(i)))
                begin
                    hdr_reg[i] <= wr_data;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/stxp_out_buffer.sv -----
// ----------------------------------------------------------------------------
// stxp_out_buffer
// result output register with one skid entry behind it
// ----------------------------------------------------------------------------
`default_nettype none

module stxp_out_buffer
    import stxp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_data,
    output logic         can_accept,
    output logic         out_valid,
    output result_t      out_data,
    input  wire logic    out_ready
);

    logic    out_valid_reg;
    logic    out_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t out_data_reg;
    result_t out_data_next;
    result_t skid_data_reg;
    result_t skid_data_next;
    logic    pop;

    assign pop        = out_valid_reg && out_ready;
    assign can_accept = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                // skid word moves up, new word (if any) takes its place
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = push;
                skid_data_next  = push_data;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

`default_nettype wire

// ----- src/stx_etx_command_frame_parser_core.sv -----
// ----------------------------------------------------------------------------
// stx_etx_command_frame_parser_core
// serial command frame parser: start byte 0x02, end byte 0x03, device id
// check and set-target volume decode
// ----------------------------------------------------------------------------
// usage
//   byte_in carries one received byte per word; result_out carries zero or
//   one result word per byte (end byte, or buffer position overflow).
//   a byte is taken in every cycle while byte_in.ready is high, and the
//   decode stage updates the position and buffer as each byte is taken;
//   a result is registered in the output register (or in the skid entry
//   while that register is full) before it appears on result_out.
//   the output has an output register plus one skid entry; byte_in.ready
//   drops only while both hold an undelivered result, so bytes that make no
//   result keep flowing past a single stalled result.
//   cfg_we/cfg_index/cfg_data write the device id characters (index 0 first,
//   index 1 second); write only while the block is idle.
//   reset clears the byte position, the kept header bytes and the output
//   stages, and loads the device id to its default.
// ----------------------------------------------------------------------------
`default_nettype none

module stx_etx_command_frame_parser_core
    import stxp_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEFAULT
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    stxp_byte_if.sink       byte_in,
    stxp_result_if.source   result_out,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [7:0] cfg_data
);

    cfg_t    cfg_reg;
    logic    accept;
    logic    has_result;
    logic    can_accept;
    result_t dec_result;
    result_t out_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.device_id_first  <= DEVICE_ID_FIRST_RESET;
            cfg_reg.device_id_second <= DEVICE_ID_SECOND_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DEVICE_ID_FIRST:  cfg_reg.device_id_first  <= cfg_data;
                CFG_DEVICE_ID_SECOND: cfg_reg.device_id_second <= cfg_data;
                default: ;
            endcase
        end
    end

    assign byte_in.ready = can_accept;
    assign accept        = byte_in.valid && can_accept;

    stxp_frame_decode #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .rx_byte    (byte_in.rx_byte),
        .cfg        (cfg_reg),
        .has_result (has_result),
        .result     (dec_result)
    );

    stxp_out_buffer u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept && has_result),
        .push_data  (dec_result),
        .can_accept (can_accept),
        .out_valid  (result_out.valid),
        .out_data   (out_data),
        .out_ready  (result_out.ready)
    );

    assign result_out.status        = 3'(out_data.status);
    assign result_out.target_volume = out_data.target_volume;
    assign result_out.frame_length  = out_data.frame_length;
    assign result_out.received_id   = out_data.received_id;

endmodule

`default_nettype wire

// ----- tb/frame_check_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_check_pkg
// expected-result tracking for the stx/etx command frame parser testbench:
// a byte-level model of the frame buffer, address compare and command decode,
// plus a queue of the results still to arrive at the output
// ----------------------------------------------------------------------------

package frame_check_pkg;

    import stxp_pkg::*;

    class frame_scoreboard;

        int unsigned depth;
        logic [7:0]  id_first;
        logic [7:0]  id_second;
        int unsigned position;
        logic [7:0]  kept [1:KEPT_BYTES];
        result_t     due_results[$];
        int unsigned failures;

        function new(int unsigned buffer_depth);
            depth = buffer_depth;
            failures = 0;
            clear();
        endfunction

        function void clear();
            id_first = DEVICE_ID_FIRST_RESET;
            id_second = DEVICE_ID_SECOND_RESET;
            position = 0;
            foreach (kept[i])
                kept[i] = 8'h00;
            due_results.delete();
        endfunction

        function void write_reg(logic index, logic [7:0] value);
            if (index == CFG_DEVICE_ID_FIRST)
                id_first = value;
            else
                id_second = value;
        endfunction

        // only header and volume positions can ever be read back
        function void store(int unsigned pos, logic [7:0] value);
            if (pos >= 1 && pos <= KEPT_BYTES)
                kept[pos] = value;
        endfunction

        function int unsigned due_count();
            return due_results.size();
        endfunction

        // called once per accepted input word
        function void note_byte(logic [7:0] rx);
            result_t     r;
            int unsigned pos;
            r = '0;
            if (rx == START_BYTE) begin
                position = 1;
            end
            else if (rx == END_BYTE) begin
                pos = position;
                position = 0;
                if (kept[1] != id_first || kept[2] != id_second) begin
                    r.status = ST_WRONG_ID;
                    r.received_id = {kept[1], kept[2]};
                end
                else if (kept[3] != CMD_SET_TARGET) begin
                    r.status = ST_ID_MATCHED;
                end
                else if (pos + 1 == SET_TARGET_LEN) begin
                    r.status = ST_VOLUME_SET;
                    r.target_volume = {kept[7], kept[6], kept[5], kept[4]};
                end
                else begin
                    // end byte lands in the buffer on a bad set-target length
                    store(pos, END_BYTE);
                    r.status = ST_LENGTH_ERROR;
                    r.frame_length = 8'(pos + 1);
                end
                due_results.push_back(r);
            end
            else begin
                store(position, rx);
                position++;
                if (position >= depth) begin
                    position = 0;
                    r.status = ST_OVERFLOW;
                    due_results.push_back(r);
                end
            end
        endfunction

        function void flag(string what, result_t want, logic [2:0] status,
                           logic [31:0] volume, logic [7:0] length, logic [15:0] rid);
            failures++;
            if (failures <= 10)
                $display("%s: expected st=%0d vol=%h len=%0d id=%h, got st=%0d vol=%h len=%0d id=%h",
                         what, want.status, want.target_volume, want.frame_length,
                         want.received_id, status, volume, length, rid);
        endfunction

        // called once per accepted output word
        function void check_result(logic [2:0] status, logic [31:0] volume,
                                   logic [7:0] length, logic [15:0] rid);
            result_t want;
            if (due_results.size() == 0) begin
                want = '0;
                flag("unexpected result", want, status, volume, length, rid);
            end
            else begin
                want = due_results.pop_front();
                if (status !== want.status || volume !== want.target_volume ||
                    length !== want.frame_length || rid !== want.received_id)
                    flag("result mismatch", want, status, volume, length, rid);
            end
        endfunction

    endclass

endpackage

// ----- tb/tb_stx_etx_command_frame_parser_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stx_etx_command_frame_parser_core
// drives byte streams of valid, malformed and over-long frames under several
// device addresses, with bursty input and a stalling result sink, and checks
// every result word against a byte-level model of the parser
// ----------------------------------------------------------------------------

module tb_stx_etx_command_frame_parser_core;

    import stxp_pkg::*;
    import frame_check_pkg::*;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_index;
    logic [7:0] cfg_data;

    stxp_byte_if   byte_ch ();
    stxp_result_if result_ch ();

    frame_scoreboard board;

    int         burst_left;
    logic [7:0] cur_first;
    logic [7:0] cur_second;

    stx_etx_command_frame_parser_core #(
        .BUFFER_DEPTH (BUFFER_DEPTH_DEFAULT)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_ch),
        .result_out (result_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5ms;
        $display("tb_stx_etx_command_frame_parser_core: FAIL");
        $finish;
    end

    // result sink
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            board.check_result(result_ch.status, result_ch.target_volume,
                               result_ch.frame_length, result_ch.received_id);
    end

    // sink stall pattern: long ready runs, short and long stalls, random toggling
    initial
    begin
        int n;
        result_ch.ready = 1'b0;
        @(negedge clk);
        forever
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    result_ch.ready = 1'b1;
                    n = $urandom_range(20, 60);
                    repeat (n) @(negedge clk);
                end
                1:
                begin
                    result_ch.ready = 1'b0;
                    n = $urandom_range(1, 8);
                    repeat (n) @(negedge clk);
                end
                2:
                begin
                    n = $urandom_range(10, 30);
                    repeat (n)
                    begin
                        result_ch.ready = $urandom_range(0, 1);
                        @(negedge clk);
                    end
                end
                default:
                begin
                    result_ch.ready = 1'b0;
                    n = $urandom_range(10, 30);
                    repeat (n) @(negedge clk);
                end
            endcase
        end
    end

    function automatic logic [7:0] plain_byte();
        logic [7:0] v;
        v = 8'($urandom_range(0, 255));
        while (v == START_BYTE || v == END_BYTE)
            v = 8'($urandom_range(0, 255));
        return v;
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_byte(input logic [7:0] rx);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                byte_ch.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 20);
        end
        burst_left--;
        byte_ch.valid = 1'b1;
        byte_ch.rx_byte = rx;
        do @(posedge clk); while (!byte_ch.ready);
        board.note_byte(rx);
        @(negedge clk);
    endtask

    task automatic send_seq(input logic [7:0] seq[$], inout int sent);
        foreach (seq[i])
            send_byte(seq[i]);
        sent += seq.size();
    endtask

    task automatic wait_idle();
        byte_ch.valid = 1'b0;
        while (board.due_count() != 0)
            @(negedge clk);
        // words that make no result may still be inside
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic index, input logic [7:0] value);
        cfg_we = 1'b1;
        cfg_index = index;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
        board.write_reg(index, value);
    endtask

    task automatic send_random_frame(inout int sent);
        logic [7:0] seq[$];
        int         kind;
        int         n;
        logic [7:0] cmd;
        kind = $urandom_range(0, 99);
        if (kind < 35) begin
            seq = '{START_BYTE, cur_first, cur_second, CMD_SET_TARGET};
            repeat (4) seq.push_back(plain_byte());
            seq.push_back(END_BYTE);
        end
        else if (kind < 48) begin
            // set-target with a bad length
            seq = '{START_BYTE, cur_first, cur_second, CMD_SET_TARGET};
            n = $urandom_range(0, 8);
            if (n == 4)
                n = 0;
            repeat (n) seq.push_back(plain_byte());
            seq.push_back(END_BYTE);
        end
        else if (kind < 60) begin
            cmd = plain_byte();
            if (cmd == CMD_SET_TARGET)
                cmd = 8'h00;
            seq = '{START_BYTE, cur_first, cur_second, cmd};
            n = $urandom_range(0, 6);
            repeat (n) seq.push_back(plain_byte());
            seq.push_back(END_BYTE);
        end
        else if (kind < 70) begin
            // address off in one or both characters
            seq.push_back(START_BYTE);
            seq.push_back($urandom_range(0, 1) ? plain_byte() : cur_first);
            seq.push_back($urandom_range(0, 1) ? plain_byte() : cur_second ^ 8'h10);
            seq.push_back($urandom_range(0, 1) ? CMD_SET_TARGET : plain_byte());
            n = $urandom_range(0, 5);
            repeat (n) seq.push_back(plain_byte());
            seq.push_back(END_BYTE);
        end
        else if (kind < 78) begin
            // frame cut short, the next one restarts it
            seq = '{START_BYTE, cur_first, cur_second, CMD_SET_TARGET};
            n = $urandom_range(1, 8);
            while (seq.size() > n)
                void'(seq.pop_back());
        end
        else if (kind < 86) begin
            n = $urandom_range(1, 8);
            repeat (n) seq.push_back(8'($urandom_range(0, 255)));
        end
        else if (kind < 94) begin
            // end byte with stale or missing header bytes
            seq.push_back(START_BYTE);
            n = $urandom_range(0, 2);
            repeat (n) seq.push_back(plain_byte());
            seq.push_back(END_BYTE);
        end
        else if (kind < 97) begin
            // longest frame that still ends before the position wraps
            seq = '{START_BYTE, cur_first, cur_second, CMD_SET_TARGET};
            repeat (BUFFER_DEPTH_DEFAULT - 5) seq.push_back(plain_byte());
            seq.push_back(END_BYTE);
        end
        else begin
            seq.push_back(START_BYTE);
            n = $urandom_range(BUFFER_DEPTH_DEFAULT - 1, BUFFER_DEPTH_DEFAULT + 12);
            repeat (n) seq.push_back(plain_byte());
        end
        send_seq(seq, sent);
    endtask

    task automatic run_address_phase(input logic [7:0] first, input logic [7:0] second,
                                     input int budget, input bit do_write);
        int sent;
        sent = 0;
        if (do_write) begin
            wait_idle();
            write_reg(CFG_DEVICE_ID_FIRST, first);
            write_reg(CFG_DEVICE_ID_SECOND, second);
        end
        cur_first = first;
        cur_second = second;
        while (sent < budget)
            send_random_frame(sent);
    endtask

    initial
    begin
        logic [7:0] seq[$];
        int         sent;
        logic [7:0] rf;
        logic [7:0] rs;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_DEVICE_ID_FIRST;
        cfg_data = 8'h00;
        byte_ch.valid = 1'b0;
        byte_ch.rx_byte = 8'h00;
        burst_left = 0;
        sent = 0;
        board = new(BUFFER_DEPTH_DEFAULT);
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // byte before any start, then an end byte with an empty buffer
        seq = '{8'h58, END_BYTE};
        // volume set with extreme payload values
        seq = {seq, START_BYTE, DEVICE_ID_FIRST_RESET, DEVICE_ID_SECOND_RESET,
               CMD_SET_TARGET, 8'h00, 8'hFF, 8'h80, 8'h01, END_BYTE};
        // set-target too short
        seq = {seq, START_BYTE, DEVICE_ID_FIRST_RESET, DEVICE_ID_SECOND_RESET,
               CMD_SET_TARGET, END_BYTE};
        // other command
        seq = {seq, START_BYTE, DEVICE_ID_FIRST_RESET, DEVICE_ID_SECOND_RESET,
               8'h41, END_BYTE};
        // wrong address
        seq = {seq, START_BYTE, DEVICE_ID_FIRST_RESET, 8'h32, END_BYTE};
        send_seq(seq, sent);

        run_address_phase(DEVICE_ID_FIRST_RESET, DEVICE_ID_SECOND_RESET, 250 - sent, 1'b0);
        run_address_phase(8'd1, 8'd255, 250, 1'b1);
        run_address_phase(8'd255, 8'd1, 250, 1'b1);
        run_address_phase(8'd1, 8'd1, 250, 1'b1);
        run_address_phase(8'd255, 8'd255, 250, 1'b1);
        rf = plain_byte();
        rs = plain_byte();
        if (rf == 8'h00)
            rf = 8'h80;
        if (rs == 8'h00)
            rs = 8'h7F;
        run_address_phase(rf, rs, 250, 1'b1);
        run_address_phase(DEVICE_ID_FIRST_RESET, DEVICE_ID_SECOND_RESET, 250, 1'b1);

        byte_ch.valid = 1'b0;
        while (board.due_count() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (board.failures == 0 && board.due_count() == 0)
            $display("tb_stx_etx_command_frame_parser_core: PASS");
        else
            $display("tb_stx_etx_command_frame_parser_core: FAIL");
        $finish;
    end

endmodule

// ----- stx_etx_command_frame_parser_core.f -----
src/stxp_pkg.sv
src/stxp_if.sv
src/stxp_frame_decode.sv
src/stxp_out_buffer.sv
src/stx_etx_command_frame_parser_core.sv
tb/frame_check_pkg.sv
tb/tb_stx_etx_command_frame_parser_core.sv
